>>> hw/rtl/region_mosaic_pixelate_unit_assert.svh
// Assertion macros shared by the checkers of the mosaic pixelate unit.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef REGION_MOSAIC_PIXELATE_UNIT_ASSERT_SVH
`define REGION_MOSAIC_PIXELATE_UNIT_ASSERT_SVH

`define RMP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define RMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rmp_pkg.sv
// Package of the mosaic pixelate unit: widths, register codes, item and
// control structs and the resync state type. Depends on nothing.
package rmp_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = 12;
   localparam int POS_W = 14;
   localparam int PIX_W = 24;
   localparam int CHAN_W = 8;

   localparam int IMAGE_WIDTH_W = 12;
   localparam int LEFT_W = 11;
   localparam int TOP_W = 12;
   localparam int RIGHT_W = 12;
   localparam int BOTTOM_W = 13;
   localparam int LEVEL_W = 7;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LEFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_TOP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_RIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BOTTOM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MOSAIC_LEVEL = 3'd5;

   localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 12'd2048;
   localparam logic [LEVEL_W-1:0] MOSAIC_LEVEL_RESET = 7'd10;

   localparam int SPAN_W_W = RIGHT_W;
   localparam int SPAN_H_W = BOTTOM_W;
   localparam int PROD_W = 20;
   localparam int RECIP_W = 21;
   localparam int QUOT_W = PROD_W + RECIP_W;
   localparam int DIV_SHIFT = 27;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1342178;
   localparam int BW_W = 13;
   localparam int BH_W = 14;

   localparam int DVD_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int REM_W = BH_W + 1;
   localparam int STEP_W = $clog2(DVD_W);

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_MUL,
      RS_DIV,
      RS_LOAD,
      RS_MOD
   } rs_state_type;

   typedef struct packed {
      logic              frame_start;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } rsp_item_type;

   typedef struct packed {
      logic [IMAGE_WIDTH_W-1:0] image_width;
      logic [LEFT_W-1:0]        region_left;
      logic [TOP_W-1:0]         region_top;
      logic [RIGHT_W-1:0]       region_right;
      logic [BOTTOM_W-1:0]      region_bottom;
   } cfg_type;

   typedef struct packed {
      logic [BW_W-1:0] block_w;
      logic [BH_W-1:0] block_h;
   } geom_type;

   typedef struct packed {
      logic             load;
      logic [COL_W-1:0] col_phase;
      logic [ROW_W-1:0] row_phase;
   } phase_load_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } pos_type;

   typedef struct packed {
      logic [COL_W-1:0] addr;
      logic             in_region;
      logic             use_mem;
      logic [PIX_W-1:0] pix;
   } slot_type;

endpackage

>>> hw/rtl/rmp_csr.sv
// Configuration registers, block size computation and phase resync sequencer.
// Depends on rmp_pkg.
module rmp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  rmp_pkg::pos_type                 pos,
   output rmp_pkg::cfg_type                 cfg,
   output rmp_pkg::geom_type                geom,
   output rmp_pkg::phase_load_type          phase_load,
   output logic                             busy
);

   logic [rmp_pkg::IMAGE_WIDTH_W-1:0] image_width_ff;
   logic [rmp_pkg::LEFT_W-1:0]        region_left_ff;
   logic [rmp_pkg::TOP_W-1:0]         region_top_ff;
   logic [rmp_pkg::RIGHT_W-1:0]       region_right_ff;
   logic [rmp_pkg::BOTTOM_W-1:0]      region_bottom_ff;
   logic [rmp_pkg::LEVEL_W-1:0]       mosaic_level_ff;

   rmp_pkg::rs_state_type state_ff, state_in;

   logic [rmp_pkg::SPAN_W_W-1:0] span_w;
   logic [rmp_pkg::SPAN_H_W-1:0] span_h;
   logic [rmp_pkg::PROD_W-1:0]   prod_w_ff, prod_h_ff;
   logic [rmp_pkg::QUOT_W-1:0]   quot_w, quot_h;
   logic [rmp_pkg::BW_W-1:0]     block_w_ff, block_w_in;
   logic [rmp_pkg::BH_W-1:0]     block_h_ff, block_h_in;
   logic [rmp_pkg::DVD_W-1:0]    dvd_w_ff, dvd_h_ff;
   logic [rmp_pkg::REM_W-1:0]    rem_w_ff, rem_h_ff, rem_w_in, rem_h_in;
   logic [rmp_pkg::REM_W-1:0]    trial_w, trial_h;
   logic [rmp_pkg::STEP_W-1:0]   step_ff;
   logic                         last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= rmp_pkg::IMAGE_WIDTH_RESET;
         region_left_ff   <= '0;
         region_top_ff    <= '0;
         region_right_ff  <= '0;
         region_bottom_ff <= '0;
         mosaic_level_ff  <= rmp_pkg::MOSAIC_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rmp_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[rmp_pkg::IMAGE_WIDTH_W-1:0];
            end
            rmp_pkg::CSR_REGION_LEFT: begin
               region_left_ff <= csr_wdata[rmp_pkg::LEFT_W-1:0];
            end
            rmp_pkg::CSR_REGION_TOP: begin
               region_top_ff <= csr_wdata[rmp_pkg::TOP_W-1:0];
            end
            rmp_pkg::CSR_REGION_RIGHT: begin
               region_right_ff <= csr_wdata[rmp_pkg::RIGHT_W-1:0];
            end
            rmp_pkg::CSR_REGION_BOTTOM: begin
               region_bottom_ff <= csr_wdata[rmp_pkg::BOTTOM_W-1:0];
            end
            rmp_pkg::CSR_MOSAIC_LEVEL: begin
               mosaic_level_ff <= csr_wdata[rmp_pkg::LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign last_step = (step_ff == rmp_pkg::STEP_W'(rmp_pkg::DVD_W - 1));

   always_comb begin
      state_in = state_ff;
      priority if (csr_we) begin
         state_in = rmp_pkg::RS_MUL;
      end else begin
         unique case (state_ff)
            rmp_pkg::RS_IDLE: state_in = rmp_pkg::RS_IDLE;
            rmp_pkg::RS_MUL:  state_in = rmp_pkg::RS_DIV;
            rmp_pkg::RS_DIV:  state_in = rmp_pkg::RS_LOAD;
            rmp_pkg::RS_LOAD: state_in = rmp_pkg::RS_MOD;
            rmp_pkg::RS_MOD: begin
               if (last_step) begin
                  state_in = rmp_pkg::RS_IDLE;
               end
            end
            default: state_in = rmp_pkg::RS_IDLE;
         endcase
      end
   end

   always_comb begin
      busy = (state_ff != rmp_pkg::RS_IDLE);
      phase_load.load = (state_ff == rmp_pkg::RS_MOD) && last_step;
      phase_load.col_phase = rem_w_in[rmp_pkg::COL_W-1:0];
      phase_load.row_phase = rem_h_in[rmp_pkg::ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmp_pkg::RS_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      span_w = (region_right_ff > rmp_pkg::RIGHT_W'(region_left_ff))
             ? region_right_ff - rmp_pkg::RIGHT_W'(region_left_ff) : '0;
      span_h = (region_bottom_ff > rmp_pkg::BOTTOM_W'(region_top_ff))
             ? region_bottom_ff - rmp_pkg::BOTTOM_W'(region_top_ff) : '0;

      quot_w = rmp_pkg::QUOT_W'(prod_w_ff) * rmp_pkg::QUOT_W'(rmp_pkg::DIV_RECIP);
      quot_h = rmp_pkg::QUOT_W'(prod_h_ff) * rmp_pkg::QUOT_W'(rmp_pkg::DIV_RECIP);
      block_w_in = quot_w[rmp_pkg::DIV_SHIFT +: rmp_pkg::BW_W];
      block_h_in = quot_h[rmp_pkg::DIV_SHIFT +: rmp_pkg::BH_W];
      if (block_w_in == '0) begin
         block_w_in = rmp_pkg::BW_W'(1);
      end
      if (block_h_in == '0) begin
         block_h_in = rmp_pkg::BH_W'(1);
      end

      trial_w = {rem_w_ff[rmp_pkg::REM_W-2:0], dvd_w_ff[rmp_pkg::DVD_W-1]};
      trial_h = {rem_h_ff[rmp_pkg::REM_W-2:0], dvd_h_ff[rmp_pkg::DVD_W-1]};
      rem_w_in = (trial_w >= rmp_pkg::REM_W'(block_w_ff))
               ? trial_w - rmp_pkg::REM_W'(block_w_ff) : trial_w;
      rem_h_in = (trial_h >= rmp_pkg::REM_W'(block_h_ff))
               ? trial_h - rmp_pkg::REM_W'(block_h_ff) : trial_h;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rmp_pkg::RS_MUL: begin
            prod_w_ff <= rmp_pkg::PROD_W'(mosaic_level_ff) * rmp_pkg::PROD_W'(span_w);
            prod_h_ff <= rmp_pkg::PROD_W'(mosaic_level_ff) * rmp_pkg::PROD_W'(span_h);
         end
         rmp_pkg::RS_DIV: begin
            block_w_ff <= block_w_in;
            block_h_ff <= block_h_in;
         end
         rmp_pkg::RS_LOAD: begin
            dvd_w_ff <= rmp_pkg::DVD_W'(pos.col - rmp_pkg::COL_W'(region_left_ff));
            dvd_h_ff <= rmp_pkg::DVD_W'(pos.row - region_top_ff);
            rem_w_ff <= '0;
            rem_h_ff <= '0;
            step_ff  <= '0;
         end
         rmp_pkg::RS_MOD: begin
            dvd_w_ff <= {dvd_w_ff[rmp_pkg::DVD_W-2:0], 1'b0};
            dvd_h_ff <= {dvd_h_ff[rmp_pkg::DVD_W-2:0], 1'b0};
            rem_w_ff <= rem_w_in;
            rem_h_ff <= rem_h_in;
            step_ff  <= step_ff + rmp_pkg::STEP_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign cfg.image_width   = image_width_ff;
   assign cfg.region_left   = region_left_ff;
   assign cfg.region_top    = region_top_ff;
   assign cfg.region_right  = region_right_ff;
   assign cfg.region_bottom = region_bottom_ff;
   assign geom.block_w      = block_w_ff;
   assign geom.block_h      = block_h_ff;

endmodule

>>> hw/rtl/rmp_scan.sv
// Raster position, block phase counters and held pixel; classifies each
// accepted item for the line store stage. Depends on rmp_pkg.
module rmp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  rmp_pkg::req_item_type   item,
   input  rmp_pkg::cfg_type        cfg,
   input  rmp_pkg::geom_type       geom,
   input  rmp_pkg::phase_load_type phase_load,
   output rmp_pkg::pos_type        pos,
   output rmp_pkg::slot_type       slot
);

   logic [rmp_pkg::COL_W-1:0] col_ff, col_in, col_start, col_eff;
   logic [rmp_pkg::ROW_W-1:0] row_ff, row_in, row_eff;
   logic [rmp_pkg::COL_W-1:0] cph_ff, cph_in, cph_use;
   logic [rmp_pkg::ROW_W-1:0] rph_ff, rph_in, rph_use;
   logic [rmp_pkg::PIX_W-1:0] held_ff, held_in, pix;
   logic [rmp_pkg::POS_W-1:0] line_len, image_w, col_x, row_x;
   logic                      in_region, line_end;

   always_comb begin
      pix = {item.red_in, item.green_in, item.blue_in};
      image_w = rmp_pkg::POS_W'(cfg.image_width);
      if (image_w == '0) begin
         line_len = rmp_pkg::POS_W'(1);
      end else if (image_w > rmp_pkg::POS_W'(rmp_pkg::MAX_WIDTH)) begin
         line_len = rmp_pkg::POS_W'(rmp_pkg::MAX_WIDTH);
      end else begin
         line_len = image_w;
      end

      col_start = item.frame_start ? '0 : col_ff;
      row_eff   = item.frame_start ? '0 : row_ff;
      col_eff   = (rmp_pkg::POS_W'(col_start) >= line_len) ? '0 : col_start;
      col_x     = rmp_pkg::POS_W'(col_eff);
      row_x     = rmp_pkg::POS_W'(row_eff);

      in_region = (col_x >= rmp_pkg::POS_W'(cfg.region_left))
               && (col_x <  rmp_pkg::POS_W'(cfg.region_right))
               && (row_x >= rmp_pkg::POS_W'(cfg.region_top))
               && (row_x <  rmp_pkg::POS_W'(cfg.region_bottom));

      cph_use = (col_x == rmp_pkg::POS_W'(cfg.region_left)) ? '0 : cph_ff;
      rph_use = (row_x == rmp_pkg::POS_W'(cfg.region_top)) ? '0 : rph_ff;
      line_end = (col_x + rmp_pkg::POS_W'(1)) >= line_len;

      held_in = (in_region && (rph_use == '0) && (cph_use == '0)) ? pix : held_ff;

      cph_in = ((rmp_pkg::POS_W'(cph_use) + rmp_pkg::POS_W'(1))
                == rmp_pkg::POS_W'(geom.block_w)) ? '0 : cph_use + rmp_pkg::COL_W'(1);
      if (line_end) begin
         col_in = '0;
         row_in = row_eff + rmp_pkg::ROW_W'(1);
         rph_in = ((rmp_pkg::POS_W'(rph_use) + rmp_pkg::POS_W'(1))
                   == rmp_pkg::POS_W'(geom.block_h)) ? '0 : rph_use + rmp_pkg::ROW_W'(1);
      end else begin
         col_in = col_eff + rmp_pkg::COL_W'(1);
         row_in = row_eff;
         rph_in = rph_use;
      end

      slot.addr      = col_eff;
      slot.in_region = in_region;
      slot.use_mem   = in_region && (rph_use != '0);
      slot.pix       = in_region ? held_in : pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cph_ff  <= '0;
         rph_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cph_ff  <= cph_in;
         rph_ff  <= rph_in;
         held_ff <= held_in;
      end else if (phase_load.load) begin
         cph_ff <= phase_load.col_phase;
         rph_ff <= phase_load.row_phase;
      end
   end

   assign pos.col = col_ff;
   assign pos.row = row_ff;

endmodule

>>> hw/rtl/rmp_line.sv
// Line store memory with read, select and write-back stage and the output
// register. Depends on rmp_pkg.
module rmp_line (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rmp_pkg::slot_type     slot,
   output logic                  hold,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rmp_pkg::rsp_item_type rsp_item
);

   logic [rmp_pkg::PIX_W-1:0] line_mem [rmp_pkg::MAX_WIDTH];

   logic                      s1_valid_ff;
   rmp_pkg::slot_type         s1_ff;
   logic [rmp_pkg::PIX_W-1:0] rd_ff;
   logic                      fwd_ff;
   logic [rmp_pkg::PIX_W-1:0] fwd_data_ff;
   logic                      out_valid_ff;
   rmp_pkg::rsp_item_type     out_ff;

   logic                      advance, wr_en;
   logic [rmp_pkg::PIX_W-1:0] result;

   always_comb begin
      advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
      hold    = s1_valid_ff && !advance;
      result  = s1_ff.use_mem ? (fwd_ff ? fwd_data_ff : rd_ff) : s1_ff.pix;
      wr_en   = advance && s1_ff.in_region;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s1_ff.addr] <= result;
      end
      if (accept) begin
         rd_ff <= line_mem[slot.addr];
      end
   end

   // A write-back in the cycle of the read is not seen by the read port.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= slot;
         fwd_ff      <= wr_en && (s1_ff.addr == slot.addr);
         fwd_data_ff <= result;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

>>> hw/rtl/region_mosaic_pixelate_unit.sv
// Mosaic pixelate unit: RGB24 raster stream in, one pixel out per pixel in.
// Top level over rmp_csr, rmp_scan and rmp_line; depends on rmp_pkg.
//
// Pixels enter on the req_ channel in raster order, one item per pixel; a
// frame_start item places its pixel at row 0, column 0. Each item yields one
// rsp_ item with the output pixel, in order, after the read stage register
// and the output register. One item is accepted every cycle while req_stall
// is low; the rate rests on the read and write-back of the line store.
// The csr_ port writes the six geometry registers. After reset and after every
// register write the unit recomputes block sizes and block phases with
// separate width and height multiplies and a bit-serial remainder, holding
// req_stall high until the new phases load. The line store is not cleared.
// Reset is synchronous; it empties the pipeline and restores register
// defaults. When the receiver stalls, the output register holds its item, one
// more item waits in the read stage, and req_stall rises after that.
module region_mosaic_pixelate_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rmp_pkg::req_item_type          req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rmp_pkg::rsp_item_type          rsp_item,
   input  logic                           csr_we,
   input  logic [rmp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rmp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rmp_pkg::cfg_type        cfg;
   rmp_pkg::geom_type       geom;
   rmp_pkg::phase_load_type phase_load;
   rmp_pkg::pos_type        pos;
   rmp_pkg::slot_type       slot;
   logic                    busy, hold, accept;

   assign req_stall = busy || hold;
   assign accept    = req_valid && !req_stall;

   rmp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pos        (pos),
      .cfg        (cfg),
      .geom       (geom),
      .phase_load (phase_load),
      .busy       (busy)
   );

   rmp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (req_item),
      .cfg        (cfg),
      .geom       (geom),
      .phase_load (phase_load),
      .pos        (pos),
      .slot       (slot)
   );

   rmp_line u_line (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .slot      (slot),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hw/rtl/rmp_check.sv
// Port-level checker for the mosaic pixelate unit and its bind statement.
// Depends on rmp_pkg and region_mosaic_pixelate_unit_assert.svh.
`include "region_mosaic_pixelate_unit_assert.svh"

module rmp_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rmp_pkg::rsp_item_type rsp_item,
   input logic                  csr_we
);

   `RMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "stalled result item changed")
   `RMP_ASSERT_NEXT(a_csr_resync, csr_we, req_stall, "input not stalled during resync")
   `RMP_ASSERT_IMPL(a_latency, req_valid && !req_stall, ##2 rsp_valid, "no result two cycles after an item")
   `RMP_ASSERT_IMPL(a_no_phantom, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result item without a source item")

endmodule

bind region_mosaic_pixelate_unit rmp_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item),
   .csr_we    (csr_we)
);
